/* hw/rtl/ertk_pkg.sv */
`timescale 1ns / 1ps
// shared types, status codes and constants of the echo request tracker
// no dependencies; imported by the slot table, round trip unit, top level and checker

package ertk_pkg;

  // slot table depth
  localparam int unsigned SLOTS_DEF = 128;

  // apb register port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic [APB_AW-3:0] REG_OWN_ID = '0;

  // result status codes
  localparam logic [2:0] ST_SENT      = 3'd0;
  localparam logic [2:0] ST_UNTRACKED = 3'd1;
  localparam logic [2:0] ST_MATCHED   = 3'd2;
  localparam logic [2:0] ST_SHORT     = 3'd3;
  localparam logic [2:0] ST_FOREIGN   = 3'd4;
  localparam logic [2:0] ST_UNKNOWN   = 3'd5;

  // reply checks: payload (length minus header) of at least 8 bytes
  localparam logic [15:0] MIN_RX_LEN     = 16'd12;
  localparam logic [15:0] RX_HDR_LEN     = 16'd4;
  localparam logic [7:0]  MSG_ECHO_REPLY = 8'd0;

  // round trip arithmetic
  localparam int unsigned USEC_W    = 20;
  localparam int unsigned DSEC_W    = 34;  // signed seconds difference with borrow
  localparam int unsigned PROD_W    = 45;  // signed milliseconds before saturation
  localparam logic [USEC_W:0] US_PER_S = 21'd1000000;
  // x / 1000 = (x * 536871) >> 29, exact for every x below 2^20
  localparam int unsigned RECIP_W     = 20;
  localparam int unsigned MS_RECIP_SH = 29;
  localparam logic [RECIP_W-1:0] MS_RECIP = 20'd536871;
  // x * 1000 = (x << 10) - (x << 4) - (x << 3)
  localparam int unsigned MS_SH_A = 10;
  localparam int unsigned MS_SH_B = 4;
  localparam int unsigned MS_SH_C = 3;

  typedef struct packed {
    logic        mode;
    logic [7:0]  msg_type;
    logic [15:0] msg_id;
    logic [15:0] seq;
    logic [15:0] received_length;
    logic [31:0] now_sec;
    logic [USEC_W-1:0] now_usec;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] sent_seq;
    logic [31:0] rtt_ms;
    logic [15:0] byte_count;
    logic [31:0] sent_total;
    logic [31:0] matched_total;
  } rsp_t;

  typedef struct packed {
    logic [15:0]       seq;
    logic [31:0]       start_sec;
    logic [USEC_W-1:0] start_usec;
  } slot_ent_t;

endpackage

/* hw/rtl/ertk_chan_if.sv */
`timescale 1ns / 1ps
// valid/ready channel carrying one item of payload type T
// no dependencies; used for the request and result channels

interface ertk_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/ertk_slot_mem.sv */
`timescale 1ns / 1ps
// slot table storage: sequence and start time per slot, one write and one read port
// depends on ertk_pkg

module ertk_slot_mem import ertk_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF,
  parameter int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  slot_ent_t        wdata_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output slot_ent_t        rdata_o
);

  slot_ent_t mem_q [SLOTS];
  slot_ent_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/ertk_rtt_unit.sv */
`timescale 1ns / 1ps
// round trip unit: time difference, x1000 by shift-add, /1000 by reciprocal multiply
// depends on ertk_pkg

module ertk_rtt_unit import ertk_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [31:0]       now_sec_i,
  input  logic [USEC_W-1:0] now_usec_i,
  input  logic [31:0]       st_sec_i,
  input  logic [USEC_W-1:0] st_usec_i,
  output logic              done_o,
  output logic [31:0]       rtt_ms_o
);

  localparam logic [1:0] R_IDLE = 2'd0;
  localparam logic [1:0] R_MUL  = 2'd1;
  localparam logic [1:0] R_DIV  = 2'd2;
  localparam logic [1:0] R_SUM  = 2'd3;

  logic [1:0]           st_q, st_d;
  logic [DSEC_W-1:0]    dsec_q, dsec_d;
  logic [USEC_W:0]      dusec_q, dusec_d;
  logic [PROD_W-1:0]    prod_q, prod_d;
  logic [USEC_W-1:0]    mag_q, mag_d;
  logic                 neg_q, neg_d;
  logic [31:0]          rtt_q, rtt_d;
  logic                 done_q, done_d;

  logic [USEC_W:0]           dusec_raw, dusec_neg;
  logic                      borrow;
  logic [PROD_W-1:0]         dsec_ext, quo_ext, quo_sgn, ms;
  logic [USEC_W+RECIP_W-1:0] quo_full;

  always_comb begin
    dusec_raw = {1'b0, now_usec_i} - {1'b0, st_usec_i};
    borrow    = dusec_raw[USEC_W];
    dusec_neg = ~dusec_q + (USEC_W+1)'(1);
    dsec_ext  = {{(PROD_W-DSEC_W){dsec_q[DSEC_W-1]}}, dsec_q};
    quo_full  = {{RECIP_W{1'b0}}, mag_q} * {{USEC_W{1'b0}}, MS_RECIP};
    quo_ext   = {{(PROD_W-USEC_W){1'b0}}, mag_q};
    quo_sgn   = neg_q ? (~quo_ext + PROD_W'(1)) : quo_ext;
    ms        = prod_q + quo_sgn;

    st_d    = st_q;
    dsec_d  = dsec_q;
    dusec_d = dusec_q;
    prod_d  = prod_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    rtt_d   = rtt_q;
    done_d  = 1'b0;

    case (st_q)
      R_IDLE: begin
        if (start_i) begin
          // borrow a second when the microsecond part goes negative
          dsec_d  = {2'b00, now_sec_i} - {2'b00, st_sec_i} - {{(DSEC_W-1){1'b0}}, borrow};
          dusec_d = borrow ? (dusec_raw + US_PER_S) : dusec_raw;
          st_d    = R_MUL;
        end
      end
      R_MUL: begin
        prod_d = (dsec_ext << MS_SH_A) - (dsec_ext << MS_SH_B) - (dsec_ext << MS_SH_C);
        neg_d  = dusec_q[USEC_W];
        mag_d  = dusec_q[USEC_W] ? dusec_neg[USEC_W-1:0] : dusec_q[USEC_W-1:0];
        st_d   = R_DIV;
      end
      R_DIV: begin
        // magnitude divided by 1000, sign applied in the sum
        mag_d = USEC_W'(quo_full >> MS_RECIP_SH);
        st_d  = R_SUM;
      end
      R_SUM: begin
        if (ms[PROD_W-1]) begin
          rtt_d = '0;
        end else if (|ms[PROD_W-2:32]) begin
          rtt_d = '1;
        end else begin
          rtt_d = ms[31:0];
        end
        done_d = 1'b1;
        st_d   = R_IDLE;
      end
      default: begin
        st_d = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= R_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dsec_q  <= dsec_d;
    dusec_q <= dusec_d;
    prod_q  <= prod_d;
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    rtt_q   <= rtt_d;
  end

  assign done_o   = done_q;
  assign rtt_ms_o = rtt_q;

endmodule

/* hw/rtl/echo_request_tracker_core.sv */
`timescale 1ns / 1ps
// echo request tracker top level: sequencer, busy bits, counters, apb register
// depends on ertk_pkg, ertk_chan_if, ertk_slot_mem, ertk_rtt_unit

// Tracks outstanding echo requests in a table of SLOTS entries. A request item
// (mode 0) claims the lowest free slot, stamps it with the low 16 bits of the
// send count and the send time; the send count always advances. A reply item
// (mode 1) must be at least 12 bytes long, of type echo reply and carry own_id;
// the lowest busy slot with its sequence is then freed and the round trip is
// reported in milliseconds, saturated to 32 bits and clamped to zero if time
// went backwards. Items are handled one at a time: a reply walks the slot
// table one entry per cycle through its single read port, a request walks
// the busy bits. A result still held on the output register holds the next
// result back until it drains. The next item is accepted while the previous
// result still waits on the output register.
// No clearing pass is needed after reset; busy bits are cleared by the reset.
// own_id sits at byte address 0 of the apb port.

module echo_request_tracker_core import ertk_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ertk_chan_if.sink         req_i,
  ertk_chan_if.source       rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SEND  = 3'd1;  // look for a free slot
  localparam logic [2:0] S_MATCH = 3'd2;  // look for the busy slot with the sequence
  localparam logic [2:0] S_RTT   = 3'd3;  // wait on the round trip unit
  localparam logic [2:0] S_FIN   = 3'd4;  // hand the result to the output register

  logic [2:0]       state_q, state_d;
  req_t             item_q, item_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic             cmp_busy_q, cmp_busy_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic [SLOTS-1:0] busy_q, busy_d;
  logic [31:0]      send_cnt_q, send_cnt_d;
  logic [31:0]      recv_cnt_q, recv_cnt_d;
  logic [15:0]      own_id_q, own_id_d;

  // result under construction
  logic [2:0]       res_status_q, res_status_d;
  logic [15:0]      res_seq_q, res_seq_d;
  logic [31:0]      res_rtt_q, res_rtt_d;
  logic [15:0]      res_bytes_q, res_bytes_d;

  // output register
  rsp_t             out_q, out_d;
  logic             out_vld_q, out_vld_d;

  logic             in_acc;
  logic [IDX_W-1:0] cur;
  logic             issue;
  logic             hit;

  logic             mem_we;
  slot_ent_t        mem_wdata;
  slot_ent_t        mem_rdata;
  logic             rtt_start;
  logic             rtt_done;
  logic [31:0]      rtt_ms;
  logic             apb_wr;

  // apb register port
  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite;
  assign prdata = (paddr[APB_AW-1:2] == REG_OWN_ID) ? {{(APB_DW-16){1'b0}}, own_id_q} : '0;

  always_comb begin
    own_id_d = own_id_q;
    if (apb_wr && (paddr[APB_AW-1:2] == REG_OWN_ID)) begin
      own_id_d = pwdata[15:0];
    end
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign in_acc      = req_i.valid && req_i.ready;
  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

  assign cur   = idx_q[IDX_W-1:0];
  assign issue = (idx_q < CNT_W'(SLOTS));
  // compare stage sees the entry read in the previous cycle
  assign hit   = cmp_vld_q && cmp_busy_q && (mem_rdata.seq == item_q.seq);

  assign mem_wdata.seq        = res_seq_q;
  assign mem_wdata.start_sec  = item_q.now_sec;
  assign mem_wdata.start_usec = item_q.now_usec;

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    idx_d        = idx_q;
    cmp_vld_d    = 1'b0;
    cmp_busy_d   = cmp_busy_q;
    cmp_idx_d    = cmp_idx_q;
    busy_d       = busy_q;
    send_cnt_d   = send_cnt_q;
    recv_cnt_d   = recv_cnt_q;
    res_status_d = res_status_q;
    res_seq_d    = res_seq_q;
    res_rtt_d    = res_rtt_q;
    res_bytes_d  = res_bytes_q;
    out_d        = out_q;
    out_vld_d    = out_vld_q;
    mem_we       = 1'b0;
    rtt_start    = 1'b0;

    // output register drains independently of the sequencer
    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          item_d      = req_i.data;
          idx_d       = '0;
          res_seq_d   = req_i.data.mode ? 16'd0 : send_cnt_q[15:0];
          res_rtt_d   = '0;
          res_bytes_d = '0;
          if (!req_i.data.mode) begin
            state_d = S_SEND;
          end else if (req_i.data.received_length < MIN_RX_LEN) begin
            res_status_d = ST_SHORT;
            state_d      = S_FIN;
          end else if ((req_i.data.msg_type != MSG_ECHO_REPLY) ||
                       (req_i.data.msg_id != own_id_q)) begin
            res_status_d = ST_FOREIGN;
            state_d      = S_FIN;
          end else begin
            state_d = S_MATCH;
          end
        end
      end
      S_SEND: begin
        if (!busy_q[cur]) begin
          // claim the lowest free slot
          mem_we       = 1'b1;
          busy_d[cur]  = 1'b1;
          res_status_d = ST_SENT;
          send_cnt_d   = send_cnt_q + 32'd1;
          state_d      = S_FIN;
        end else if (cur == LAST_IDX) begin
          // table full, request goes untracked
          res_status_d = ST_UNTRACKED;
          send_cnt_d   = send_cnt_q + 32'd1;
          state_d      = S_FIN;
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      S_MATCH: begin
        if (issue) begin
          idx_d      = idx_q + CNT_W'(1);
          cmp_vld_d  = 1'b1;
          cmp_idx_d  = cur;
          cmp_busy_d = busy_q[cur];
        end
        if (hit) begin
          busy_d[cmp_idx_q] = 1'b0;
          rtt_start         = 1'b1;
          recv_cnt_d        = recv_cnt_q + 32'd1;
          res_bytes_d       = item_q.received_length - RX_HDR_LEN;
          res_status_d      = ST_MATCHED;
          cmp_vld_d         = 1'b0;
          state_d           = S_RTT;
        end else if (cmp_vld_q && (cmp_idx_q == LAST_IDX)) begin
          res_status_d = ST_UNKNOWN;
          cmp_vld_d    = 1'b0;
          state_d      = S_FIN;
        end
      end
      S_RTT: begin
        if (rtt_done) begin
          res_rtt_d = rtt_ms;
          state_d   = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_d.status        = res_status_q;
          out_d.sent_seq      = res_seq_q;
          out_d.rtt_ms        = res_rtt_q;
          out_d.byte_count    = res_bytes_q;
          out_d.sent_total    = send_cnt_q;
          out_d.matched_total = recv_cnt_q;
          out_vld_d           = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cmp_vld_q  <= 1'b0;
      busy_q     <= '0;
      send_cnt_q <= '0;
      recv_cnt_q <= '0;
      own_id_q   <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cmp_vld_q  <= cmp_vld_d;
      busy_q     <= busy_d;
      send_cnt_q <= send_cnt_d;
      recv_cnt_q <= recv_cnt_d;
      own_id_q   <= own_id_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    idx_q        <= idx_d;
    cmp_busy_q   <= cmp_busy_d;
    cmp_idx_q    <= cmp_idx_d;
    res_status_q <= res_status_d;
    res_seq_q    <= res_seq_d;
    res_rtt_q    <= res_rtt_d;
    res_bytes_q  <= res_bytes_d;
    out_q        <= out_d;
  end

  ertk_slot_mem #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cur),
    .wdata_i (mem_wdata),
    .re_i    ((state_q == S_MATCH) && issue),
    .raddr_i (cur),
    .rdata_o (mem_rdata)
  );

  ertk_rtt_unit u_rtt_unit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rtt_start),
    .now_sec_i  (item_q.now_sec),
    .now_usec_i (item_q.now_usec),
    .st_sec_i   (mem_rdata.start_sec),
    .st_usec_i  (mem_rdata.start_usec),
    .done_o     (rtt_done),
    .rtt_ms_o   (rtt_ms)
  );

endmodule

/* hw/rtl/ertk_checker.sv */
`timescale 1ns / 1ps
// port-level checks of the echo request tracker, bound to the top level
// depends on ertk_pkg and echo_request_tracker_core

module ertk_checker import ertk_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input rsp_t out_data_i
);

  logic       in_acc, out_acc;
  logic [1:0] pend_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("input ready right after an accepted item");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result without an outstanding item");

  a_fields_zero_unless_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status != ST_MATCHED) |->
      (out_data_i.rtt_ms == 32'd0) && (out_data_i.byte_count == 16'd0))
    else $error("round trip or byte count set without a match");

endmodule

bind echo_request_tracker_core ertk_checker u_ertk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_data_i  (rsp_o.data)
);
